// File: design/bpfa_pkg.sv
// Shared types and constants for the bitmap page frame allocator.
package bpfa_pkg;

    // Width of the page count register.
    localparam int CFG_W = 13;
    // Reset value of the page count register.
    localparam logic [CFG_W-1:0] TOTAL_PAGES_RESET = 13'd4096;
    // One map word holds the reserved bits of this many pages.
    localparam int WORD_W = 64;
    // Bits that select a page inside a map word.
    localparam int BIT_W = 6;
    // Width of the returned page address.
    localparam int PADDR_W = 24;
    // Width of the address and length fields of a request.
    localparam int BYTE_W = 32;

    // Request opcodes.
    typedef enum logic [1:0] {
        CMD_MARK_AVAIL    = 2'd0,
        CMD_MARK_RESERVED = 2'd1,
        CMD_ALLOC         = 2'd2,
        CMD_FREE          = 2'd3
    } cmd_t;

    // One request.
    typedef struct packed {
        cmd_t              command;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] length;
    } req_t;

    // One result.
    typedef struct packed {
        logic [PADDR_W-1:0] page_address;
        logic               ok;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic prep;
        logic walk;
    } dp_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic walk_done;
    } dp_stat_t;

endpackage

// File: design/bitmap_page_frame_allocator.sv
// Top level of the bitmap page frame allocator.
// After reset the map is set to all reserved by a clearing pass over every map word; busy is high.
// A request is loaded in idle, its span is clipped in the setup state, and the walk then reads its
// map words, none for an empty span; an allocate walks up to limit/64 words, rounded up, to a hit.
// The next request can be accepted in the strobe cycle. The walk is set by the single read port
// of the map memory, one word per cycle.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  req_t             req,
    output logic             busy,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // Controller.
    bpfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    // Datapath.
    bpfa_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .ctrl      (ctrl),
        .stat      (stat),
        .result    (result)
    );

endmodule

// File: design/bpfa_ctrl.sv
// Controller state machine of the bitmap page frame allocator.
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl,
    output logic     busy,
    output logic     done
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } state_t;

    state_t state_reg;
    logic   done_reg;

    // State and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (stat.clr_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    if (stat.walk_done)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // Datapath commands decoded from the state.
    always_comb
    begin
        ctrl.clr_step = (state_reg == ST_CLEAR);
        ctrl.load     = (state_reg == ST_IDLE) && start;
        ctrl.prep     = (state_reg == ST_SETUP);
        ctrl.walk     = (state_reg == ST_WALK);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // A result only follows the end of a map walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_WALK))
        else $error("result strobe without a finished walk");

    // While idle the datapath has no read in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> stat.walk_done)
        else $error("datapath active while controller is idle");

endmodule

// File: design/bpfa_datapath.sv
// Datapath of the bitmap page frame allocator: page map memory, span math and word walk.
module bpfa_datapath
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  req_t             req,
    input  dp_ctrl_t         ctrl,
    output dp_stat_t         stat,
    output result_t          result
);

    localparam int MAP_WORDS = MAX_PAGES / WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FPW       = AW + BIT_W;
    localparam int PW        = ((34 - PAGE_SHIFT) > 17) ? (34 - PAGE_SHIFT) : 17;
    localparam logic [PW-1:0]     MAX_PAGES_P = PW'(MAX_PAGES);
    localparam logic [BYTE_W:0]   ROUND_ADD   = (BYTE_W + 1)'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [AW-1:0]     LAST_WORD   = AW'(MAP_WORDS - 1);
    localparam logic [BIT_W-1:0]  TOP_BIT     = BIT_W'(WORD_W - 1);

    // Page map memory.
    logic [WORD_W-1:0] map_mem [MAP_WORDS];
    logic [WORD_W-1:0] rd_data_reg;

    // Control registers.
    logic [CFG_W-1:0] total_pages_reg;
    logic [AW-1:0]    clr_reg;
    logic             iss_active_reg;
    logic             s1_valid_reg;
    logic             found_reg;

    // Payload registers.
    cmd_t             cmd_reg;
    logic [PW-1:0]    first_reg;
    logic [PW-1:0]    count_reg;
    logic [PW-1:0]    lim_reg;
    logic [PW-1:0]    end_reg;
    logic [AW-1:0]    iss_word_reg;
    logic [AW-1:0]    s1_word_reg;
    logic [FPW-1:0]   page_reg;

    logic [CFG_W-1:0]  tp_round;
    logic [PW-1:0]     lim_next;
    logic [PW-1:0]     first_next;
    logic [PW-1:0]     count_next;
    logic [BYTE_W:0]   len_up_sum;
    logic [PW-1:0]     span_sum;
    logic [PW-1:0]     end_next;
    logic [PW-1:0]     end_m1;
    logic [AW-1:0]     first_word;
    logic [AW-1:0]     last_word;
    logic [BIT_W-1:0]  lo_bit;
    logic [BIT_W-1:0]  hi_bit;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] low_one;
    logic [BIT_W-1:0]  bit_idx;
    logic              rd_en;
    logic              s1_active;
    logic              found_now;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [31:0]       page_full;

    // Usable page limit: page count rounded down to a multiple of 8, capped at the map size.
    always_comb
    begin
        tp_round = {total_pages_reg[CFG_W-1:3], 3'b000};
        lim_next = (PW'(tp_round) > MAX_PAGES_P) ? MAX_PAGES_P : PW'(tp_round);
    end

    // First page and page count of the request.
    always_comb
    begin
        len_up_sum = {1'b0, req.length} + ROUND_ADD;
        first_next = PW'(req.address >> PAGE_SHIFT);
        count_next = '0;
        unique case (req.command)
            CMD_MARK_AVAIL:    count_next = PW'(req.length >> PAGE_SHIFT);
            CMD_MARK_RESERVED: count_next = PW'(len_up_sum >> PAGE_SHIFT);
            CMD_ALLOC:
            begin
                first_next = '0;
                count_next = MAX_PAGES_P;
            end
            CMD_FREE:          count_next = PW'(1);
            default:           count_next = '0;
        endcase
    end

    // End of the span, clipped to the limit; equal to the first page when empty.
    always_comb
    begin
        span_sum = first_reg + count_reg;
        if (first_reg >= lim_reg)
        begin
            end_next = first_reg;
        end
        else if (span_sum > lim_reg)
        begin
            end_next = lim_reg;
        end
        else
        begin
            end_next = span_sum;
        end
    end

    // Bit mask of the span inside the word under work.
    always_comb
    begin
        end_m1     = end_reg - PW'(1);
        first_word = first_reg[FPW-1:BIT_W];
        last_word  = end_m1[FPW-1:BIT_W];
        lo_bit     = (s1_word_reg == first_word) ? first_reg[BIT_W-1:0] : '0;
        hi_bit     = (s1_word_reg == last_word) ? end_m1[BIT_W-1:0] : TOP_BIT;
        mask       = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (TOP_BIT - hi_bit));
    end

    // Lowest free page inside the span of the word under work.
    always_comb
    begin
        free_bits = ~rd_data_reg & mask;
        low_one   = free_bits & (~free_bits + WORD_W'(1));
        bit_idx   = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (low_one[i])
            begin
                bit_idx = bit_idx | BIT_W'(i);
            end
        end
    end

    assign rd_en     = ctrl.walk && iss_active_reg;
    assign s1_active = ctrl.walk && s1_valid_reg;
    assign found_now = s1_active && (cmd_reg == CMD_ALLOC) && (|free_bits);

    // Memory write: clearing pass or read-modify-write of a walked word.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = s1_word_reg;
        mem_wdata = rd_data_reg;
        if (ctrl.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = {WORD_W{1'b1}};
        end
        else if (s1_active)
        begin
            unique case (cmd_reg)
                CMD_MARK_AVAIL, CMD_FREE:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg & ~mask;
                end
                CMD_MARK_RESERVED:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg | mask;
                end
                CMD_ALLOC:
                begin
                    mem_we    = found_now;
                    mem_wdata = rd_data_reg | low_one;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    // Page map storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[iss_word_reg];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg <= TOTAL_PAGES_RESET;
            clr_reg         <= '0;
            iss_active_reg  <= 1'b0;
            s1_valid_reg    <= 1'b0;
            found_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_pages_reg <= cfg_wdata;
            end
            if (ctrl.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (ctrl.load)
            begin
                found_reg <= 1'b0;
            end
            if (ctrl.prep)
            begin
                iss_active_reg <= (end_next != first_reg);
                s1_valid_reg   <= 1'b0;
            end
            else if (ctrl.walk)
            begin
                if (found_now)
                begin
                    iss_active_reg <= 1'b0;
                    s1_valid_reg   <= 1'b0;
                    found_reg      <= 1'b1;
                end
                else
                begin
                    s1_valid_reg <= iss_active_reg;
                    if (iss_active_reg && (iss_word_reg == last_word))
                    begin
                        iss_active_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lim_reg <= lim_next;
        if (ctrl.load)
        begin
            cmd_reg   <= req.command;
            first_reg <= first_next;
            count_reg <= count_next;
        end
        if (ctrl.prep)
        begin
            end_reg      <= end_next;
            iss_word_reg <= first_reg[FPW-1:BIT_W];
        end
        else if (rd_en)
        begin
            iss_word_reg <= iss_word_reg + AW'(1);
        end
        if (ctrl.walk)
        begin
            s1_word_reg <= iss_word_reg;
        end
        if (found_now)
        begin
            page_reg <= {s1_word_reg, bit_idx};
        end
    end

    // Status and result.
    always_comb
    begin
        stat.clr_last       = (clr_reg == LAST_WORD);
        stat.walk_done      = !iss_active_reg && !s1_valid_reg;
        page_full           = 32'(page_reg) << PAGE_SHIFT;
        result.page_address = found_reg ? page_full[PADDR_W-1:0] : '0;
        result.ok           = (cmd_reg != CMD_ALLOC) || found_reg;
    end

    // A word is processed only after its read was issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(iss_active_reg))
        else $error("word processed without an issued read");

    // Only an allocate request can find a page.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_reg) |-> (cmd_reg == CMD_ALLOC))
        else $error("page found outside an allocate request");

endmodule

// File: bench/tb_bitmap_page_frame_allocator.sv
// Self-checking testbench for the bitmap page frame allocator with a built-in page map predictor.
module tb_bitmap_page_frame_allocator;
    import bpfa_pkg::*;

    localparam int MAX_PAGES   = 4096;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 8;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    req_t             req = '0;
    logic             busy;
    logic             done;
    result_t          result;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Requests waiting to be issued, and results predicted for issued requests.
    req_t    request_queue[$];
    result_t pending_page_results[$];

    // Predictor state: one reserved bit per page and the page count register.
    bit [MAX_PAGES-1:0] reserved_map = '1;
    bit [CFG_W-1:0]     model_total_pages = TOTAL_PAGES_RESET;

    int  send_idle_pct = 0;
    bit  taken = 1'b0;
    int  cycle_count = 0;
    int  fail_count = 0;
    int  result_count = 0;
    int  grants = 0;
    int  refusals = 0;
    int  settings_count = 1;

    bitmap_page_frame_allocator #(
        .MAX_PAGES (MAX_PAGES),
        .PAGE_SHIFT(PAGE_SHIFT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Usable pages: the register rounded down to a multiple of 8, capped at the map size.
    function automatic longint unsigned usable_pages(bit [CFG_W-1:0] total);
        longint unsigned lim;
        lim = (longint'(total) / 8) * 8;
        if (lim > MAX_PAGES)
        begin
            lim = MAX_PAGES;
        end
        return lim;
    endfunction

    // Set or clear a run of pages, clipped at the usable limit.
    function automatic void update_span(longint unsigned first, longint unsigned count,
                                        bit reserve);
        longint unsigned lim;
        longint unsigned stop;
        lim = usable_pages(model_total_pages);
        if (first >= lim)
        begin
            return;
        end
        stop = (count > lim - first) ? lim : first + count;
        for (longint unsigned p = first; p < stop; p++)
        begin
            reserved_map[p] = reserve;
        end
    endfunction

    // Apply one request to the predicted map and return the result it should give.
    function automatic result_t compute_page_result(req_t r);
        result_t         res;
        longint unsigned addr;
        longint unsigned len;
        longint unsigned lim;
        addr = r.address;
        len  = r.length;
        res.page_address = '0;
        res.ok = 1'b1;
        case (r.command)
            CMD_MARK_AVAIL:
                update_span(addr >> PAGE_SHIFT, len >> PAGE_SHIFT, 1'b0);
            CMD_MARK_RESERVED:
                update_span(addr >> PAGE_SHIFT, (len + PAGE_BYTES - 1) >> PAGE_SHIFT, 1'b1);
            CMD_ALLOC:
            begin
                lim = usable_pages(model_total_pages);
                res.ok = 1'b0;
                for (longint unsigned p = 0; p < lim; p++)
                begin
                    if (!reserved_map[p])
                    begin
                        reserved_map[p] = 1'b1;
                        res.page_address = PADDR_W'(p << PAGE_SHIFT);
                        res.ok = 1'b1;
                        break;
                    end
                end
            end
            default:
                update_span(addr >> PAGE_SHIFT, 1, 1'b0);
        endcase
        return res;
    endfunction

    function automatic req_t make_request(cmd_t c, bit [BYTE_W-1:0] a, bit [BYTE_W-1:0] l);
        req_t r;
        r.command = c;
        r.address = a;
        r.length  = l;
        return r;
    endfunction

    // Random request: mostly pages up to just past the usable limit and short ranges,
    // with some fully random addresses and lengths.
    function automatic req_t random_request(int lim);
        int   pick;
        cmd_t c;
        bit [BYTE_W-1:0] a;
        bit [BYTE_W-1:0] l;
        pick = $urandom_range(99);
        if (pick < 40)
            c = CMD_ALLOC;
        else if (pick < 65)
            c = CMD_FREE;
        else if (pick < 85)
            c = CMD_MARK_AVAIL;
        else
            c = CMD_MARK_RESERVED;
        if ($urandom_range(99) < 85)
            a = ($urandom_range(lim + 15) << PAGE_SHIFT) | $urandom_range(PAGE_BYTES - 1);
        else
            a = $urandom;
        pick = $urandom_range(99);
        if (pick < 70)
            l = $urandom_range(8 * PAGE_BYTES);
        else if (pick < 90)
            l = $urandom_range(300 * PAGE_BYTES);
        else
            l = $urandom;
        return make_request(c, a, l);
    endfunction

    // Wait until every request has been issued and answered, then let the block settle.
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (request_queue.size() != 0 || start || pending_page_results.size() != 0 || busy);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_page_count(bit [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings_count++;
    endtask

    task automatic queue_random(int count, int lim);
        for (int i = 0; i < count; i++)
        begin
            request_queue.push_back(random_request(lim));
        end
    endtask

    // Request driver: holds a request until it is taken, then issues the next one or idles.
    always @(negedge clk)
    begin : drive_requests
        logic next_start;
        req_t next_req;
        if (rst_n)
        begin
            next_start = start;
            next_req   = req;
            if (!start || taken)
            begin
                next_start = 1'b0;
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_start = 1'b1;
                    next_req   = request_queue.pop_front();
                end
            end
            start <= next_start;
            req   <= next_req;
        end
    end

    // Result monitor: checks each strobe, predicts each taken request, tracks the register.
    always @(posedge clk)
    begin : check_results
        result_t want;
        cycle_count++;
        if (rst_n)
        begin
            taken <= start && !busy;
            if (done)
            begin
                if (pending_page_results.size() == 0)
                begin
                    $error("result strobe with no request outstanding: page_address %h ok %b",
                           result.page_address, result.ok);
                    fail_count++;
                end
                else
                begin
                    want = pending_page_results.pop_front();
                    result_count++;
                    if (result.page_address !== want.page_address)
                    begin
                        $error("page_address mismatch: expected %h, actual %h",
                               want.page_address, result.page_address);
                        fail_count++;
                    end
                    if (result.ok !== want.ok)
                    begin
                        $error("ok mismatch: expected %b, actual %b", want.ok, result.ok);
                        fail_count++;
                    end
                    if (want.ok && want.page_address != '0 || want.ok && result.ok)
                        grants += 0;
                end
            end
            if (start && !busy)
            begin
                want = compute_page_result(req);
                if (req.command == CMD_ALLOC)
                begin
                    if (want.ok)
                        grants++;
                    else
                        refusals++;
                end
                pending_page_results.push_back(want);
            end
            if (cfg_we)
            begin
                model_total_pages = cfg_wdata;
            end
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus: directed requests at reset settings, then random phases at several page counts.
    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Everything is reserved after reset, so the first allocate must fail.
        request_queue.push_back(make_request(CMD_ALLOC, 32'h0, 32'h0));
        request_queue.push_back(make_request(CMD_FREE, 32'h0, 32'hFFFF_FFFF));
        request_queue.push_back(make_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0));
        // A length one byte short of a page clears nothing.
        request_queue.push_back(make_request(CMD_MARK_AVAIL, 32'h1000, 32'hFFF));
        // Unaligned start: pages 1 to 3 become free.
        request_queue.push_back(make_request(CMD_MARK_AVAIL, 32'h1800, 32'h3000));
        // One byte reserves a whole page; a zero length reserves nothing.
        request_queue.push_back(make_request(CMD_MARK_RESERVED, 32'h2000, 32'h1));
        request_queue.push_back(make_request(CMD_MARK_RESERVED, 32'h3000, 32'h0));
        request_queue.push_back(make_request(CMD_ALLOC, 32'h0, 32'h0));
        request_queue.push_back(make_request(CMD_ALLOC, 32'h0, 32'h0));
        // Free everything with the widest range, then allocate from the bottom.
        request_queue.push_back(make_request(CMD_MARK_AVAIL, 32'h0, 32'hFFFF_FFFF));
        request_queue.push_back(make_request(CMD_ALLOC, 32'h0, 32'h0));
        // Pages at or past the limit are ignored.
        request_queue.push_back(make_request(CMD_FREE, 32'hFFFF_FFFF, 32'h0));
        request_queue.push_back(make_request(CMD_MARK_RESERVED, 32'hFFFF_F000, 32'hFFFF_FFFF));
        request_queue.push_back(make_request(CMD_MARK_AVAIL, 32'h0100_0000, 32'hFFFF_FFFF));
        // Reserve all, open only the last page, take it, then run out.
        request_queue.push_back(make_request(CMD_MARK_RESERVED, 32'h0, 32'hFFFF_FFFF));
        request_queue.push_back(make_request(CMD_MARK_AVAIL, 32'h00FF_F000, 32'h1000));
        request_queue.push_back(make_request(CMD_ALLOC, 32'h0, 32'h0));
        request_queue.push_back(make_request(CMD_ALLOC, 32'h0, 32'h0));
        request_queue.push_back(make_request(CMD_FREE, 32'h00FF_FABC, 32'h0));
        request_queue.push_back(make_request(CMD_MARK_AVAIL, 32'h0001_0000, 32'h0002_0000));
        request_queue.push_back(make_request(CMD_ALLOC, 32'h0, 32'h0));
        wait_idle();

        // Page count just under the map size, no idling.
        write_page_count(13'd4095);
        send_idle_pct = 0;
        queue_random(300, 4088);
        wait_idle();

        // Small map, sender mostly idle.
        write_page_count(13'd100);
        send_idle_pct = 75;
        queue_random(300, 96);
        wait_idle();

        // Largest register value, capped at the map size.
        write_page_count(13'h1FFF);
        send_idle_pct = 0;
        queue_random(250, 4096);
        wait_idle();

        // No usable pages at all: every allocate is refused.
        write_page_count(13'd7);
        send_idle_pct = 36;
        queue_random(50, 0);
        wait_idle();
        write_page_count(13'd0);
        queue_random(50, 0);
        wait_idle();

        // Mid-sized map with a limit that is not word aligned.
        write_page_count(13'd1000);
        send_idle_pct = 36;
        queue_random(300, 1000);
        wait_idle();

        $display("Checked %0d results over %0d page-count settings.",
                 result_count, settings_count);
        $display("Allocations granted: %0d, refused for lack of free pages: %0d.",
                 grants, refusals);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
design/bpfa_pkg.sv
design/bpfa_ctrl.sv
design/bpfa_datapath.sv
design/bitmap_page_frame_allocator.sv
bench/tb_bitmap_page_frame_allocator.sv
